@@ hw/rtl/sdl_pkg.sv @@
// ----------------------------------------------------------------------------
// Spring direction local step package
// Shared types, widths and stage counts for the spring direction pipeline.
// ----------------------------------------------------------------------------
package sdl_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int REST_WIDTH  = COORD_WIDTH - 1;
    localparam int UNIT_BITS   = 30;
    localparam int A_WIDTH     = UNIT_BITS + 1;
    localparam int SQ_WIDTH    = 2 * A_WIDTH;
    localparam int SUM_WIDTH   = 64;
    localparam int ROOT_WIDTH  = 32;
    localparam int QUOT_WIDTH  = UNIT_BITS + 1;
    localparam int DIVD_WIDTH  = A_WIDTH + UNIT_BITS + 1;

    localparam int FRONT_STAGES = 5;
    localparam int SQRT_STAGES  = SUM_WIDTH / 2;
    localparam int DIV_STAGES   = QUOT_WIDTH + 1;
    localparam int BACK_STAGES  = 2;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + BACK_STAGES;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] first_z;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] second_z;
        logic [REST_WIDTH-1:0]         rest_len;
    } sdl_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
    } sdl_out_t;

    // Per-item side information that rides along the pipeline.
    typedef struct packed {
        logic [2:0]            neg;
        logic                  zero;
        logic [REST_WIDTH-1:0] rest;
    } sdl_side_t;

    typedef logic [2:0][A_WIDTH-1:0] sdl_axes_t;

endpackage

@@ hw/rtl/sdl_front.sv @@
// ----------------------------------------------------------------------------
// Spring direction front end
// Difference, magnitude, largest normalized to [2^30, 2^31), sum of squares.
// ----------------------------------------------------------------------------
module sdl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  sdl_pkg::sdl_in_t            in_item,
    output logic                        out_valid,
    output logic [sdl_pkg::SUM_WIDTH-1:0] out_sum,
    output sdl_pkg::sdl_axes_t          out_a,
    output sdl_pkg::sdl_side_t          out_side
);
    import sdl_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic [FRONT_STAGES:1]          v_reg;
    logic [2:0][DW-1:0]             d_reg;
    logic [2:0][COORD_WIDTH-1:0]    mag_reg;
    sdl_axes_t                      a3_reg, a4_reg, a5_reg;
    logic [2:0][SQ_WIDTH-1:0]       sq_reg;
    logic [SUM_WIDTH-1:0]           sum_reg;
    sdl_side_t                      s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;

    logic [2:0][COORD_WIDTH-1:0]    mag_next;
    logic [2:0]                     neg_next;
    logic [COORD_WIDTH-1:0]         or_bits;
    logic [$clog2(COORD_WIDTH)-1:0] top_idx;
    sdl_axes_t                      a_next;
    logic [COORD_WIDTH+UNIT_BITS-1:0] wide;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = d_reg[i][DW-1];
            mag_next[i] = neg_next[i] ? COORD_WIDTH'(-d_reg[i]) : COORD_WIDTH'(d_reg[i]);
        end
    end

    // The top set bit of the OR of the magnitudes is the top bit of the largest.
    always_comb
    begin
        or_bits = mag_reg[0] | mag_reg[1] | mag_reg[2];
        top_idx = '0;
        for (int b = 0; b < COORD_WIDTH; b++)
        begin
            if (or_bits[b])
            begin
                top_idx = ($clog2(COORD_WIDTH))'(b);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            wide      = {mag_reg[i], {UNIT_BITS{1'b0}}} >> top_idx;
            a_next[i] = wide[A_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[FRONT_STAGES-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0] <= {in_item.first_x[COORD_WIDTH-1], in_item.first_x}
                  - {in_item.second_x[COORD_WIDTH-1], in_item.second_x};
        d_reg[1] <= {in_item.first_y[COORD_WIDTH-1], in_item.first_y}
                  - {in_item.second_y[COORD_WIDTH-1], in_item.second_y};
        d_reg[2] <= {in_item.first_z[COORD_WIDTH-1], in_item.first_z}
                  - {in_item.second_z[COORD_WIDTH-1], in_item.second_z};
        s1_reg <= '{neg: 3'b000, zero: 1'b0, rest: in_item.rest_len};

        mag_reg <= mag_next;
        s2_reg  <= '{neg: neg_next, zero: s1_reg.zero, rest: s1_reg.rest};

        a3_reg <= a_next;
        s3_reg <= '{neg: s2_reg.neg, zero: (or_bits == '0), rest: s2_reg.rest};

        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= SQ_WIDTH'(a3_reg[i]) * SQ_WIDTH'(a3_reg[i]);
        end
        a4_reg <= a3_reg;
        s4_reg <= s3_reg;

        sum_reg <= SUM_WIDTH'(sq_reg[0]) + SUM_WIDTH'(sq_reg[1]) + SUM_WIDTH'(sq_reg[2]);
        a5_reg  <= a4_reg;
        s5_reg  <= s4_reg;
    end

    assign out_valid = v_reg[FRONT_STAGES];
    assign out_sum   = sum_reg;
    assign out_a     = a5_reg;
    assign out_side  = s5_reg;

endmodule

@@ hw/rtl/sdl_sqrt.sv @@
// ----------------------------------------------------------------------------
// Spring direction square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sdl_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [sdl_pkg::SUM_WIDTH-1:0] in_op,
    input  sdl_pkg::sdl_axes_t            in_a,
    input  sdl_pkg::sdl_side_t            in_side,
    output logic                          out_valid,
    output logic [sdl_pkg::ROOT_WIDTH-1:0] out_root,
    output sdl_pkg::sdl_axes_t            out_a,
    output sdl_pkg::sdl_side_t            out_side
);
    import sdl_pkg::*;

    logic [SQRT_STAGES-1:0]  v_reg;
    logic [SUM_WIDTH-1:0]    op_reg   [SQRT_STAGES];
    logic [SUM_WIDTH-1:0]    res_reg  [SQRT_STAGES];
    sdl_axes_t               a_reg    [SQRT_STAGES];
    sdl_side_t               side_reg [SQRT_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_step
        localparam logic [SUM_WIDTH-1:0] ONE = SUM_WIDTH'(1) << (SUM_WIDTH - 2 - 2 * k);
        logic [SUM_WIDTH-1:0] op_in;
        logic [SUM_WIDTH-1:0] res_in;
        sdl_axes_t            a_in;
        sdl_side_t            side_in;
        logic [SUM_WIDTH-1:0] trial;
        logic                 take;

        if (k == 0)
        begin : g_first
            assign op_in   = in_op;
            assign res_in  = '0;
            assign a_in    = in_a;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign op_in   = op_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign a_in    = a_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = res_in + ONE;
        assign take  = (op_in >= trial);

        always_ff @(posedge clk)
        begin
            op_reg[k]   <= take ? op_in - trial : op_in;
            res_reg[k]  <= take ? (res_in >> 1) + ONE : res_in >> 1;
            a_reg[k]    <= a_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = res_reg[SQRT_STAGES-1][ROOT_WIDTH-1:0];
    assign out_a     = a_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

@@ hw/rtl/sdl_div.sv @@
// ----------------------------------------------------------------------------
// Spring direction divider
// Three restoring dividers in lockstep giving rounded unit magnitudes.
// ----------------------------------------------------------------------------
module sdl_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [sdl_pkg::ROOT_WIDTH-1:0] in_root,
    input  sdl_pkg::sdl_axes_t             in_a,
    input  sdl_pkg::sdl_side_t             in_side,
    output logic                           out_valid,
    output sdl_pkg::sdl_axes_t             out_u,
    output sdl_pkg::sdl_side_t             out_side
);
    import sdl_pkg::*;

    localparam int STEPS = QUOT_WIDTH;

    logic [STEPS:0]              v_reg;
    logic [2:0][DIVD_WIDTH-1:0]  rem0_reg;
    logic [ROOT_WIDTH-1:0]       dvs0_reg;
    sdl_side_t                   side0_reg;

    logic [2:0][DIVD_WIDTH-1:0]  rem_reg  [STEPS];
    logic [2:0][QUOT_WIDTH-1:0]  q_reg    [STEPS];
    logic [ROOT_WIDTH-1:0]       dvs_reg  [STEPS];
    sdl_side_t                   side_reg [STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STEPS-1:0], in_valid};
        end
    end

    // Dividend is a * 2^30 plus half the divisor, for round to nearest.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem0_reg[i] <= {1'b0, in_a[i], {UNIT_BITS{1'b0}}}
                         + DIVD_WIDTH'(in_root >> 1);
        end
        dvs0_reg  <= in_root;
        side0_reg <= in_side;
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int BIT = STEPS - 1 - k;
        logic [2:0][DIVD_WIDTH-1:0] rem_in;
        logic [2:0][QUOT_WIDTH-1:0] q_in;
        logic [ROOT_WIDTH-1:0]      dvs_in;
        sdl_side_t                  side_in;
        logic [DIVD_WIDTH-1:0]      shifted;

        if (k == 0)
        begin : g_first
            assign rem_in  = rem0_reg;
            assign q_in    = '0;
            assign dvs_in  = dvs0_reg;
            assign side_in = side0_reg;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign shifted = DIVD_WIDTH'(dvs_in) << BIT;

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= shifted)
                begin
                    rem_reg[k][i] <= rem_in[i] - shifted;
                    q_reg[k][i]   <= q_in[i] | (QUOT_WIDTH'(1) << BIT);
                end
                else
                begin
                    rem_reg[k][i] <= rem_in[i];
                    q_reg[k][i]   <= q_in[i];
                end
            end
            dvs_reg[k]  <= dvs_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_u     = q_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

@@ hw/rtl/sdl_back.sv @@
// ----------------------------------------------------------------------------
// Spring direction back end
// Scales unit magnitudes by the rest length, restores sign and saturates.
// ----------------------------------------------------------------------------
module sdl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sdl_pkg::sdl_axes_t in_u,
    input  sdl_pkg::sdl_side_t in_side,
    output logic               done,
    output sdl_pkg::sdl_out_t  result
);
    import sdl_pkg::*;

    localparam int PW = REST_WIDTH + QUOT_WIDTH;
    localparam int VW = PW - UNIT_BITS;

    localparam logic [VW-1:0] POS_MAX = VW'((64'd1 << (COORD_WIDTH - 1)) - 1);
    localparam logic [VW-1:0] NEG_MAX = VW'(64'd1 << (COORD_WIDTH - 1));
    localparam logic [PW-1:0] HALF    = PW'(1) << (UNIT_BITS - 1);

    logic [1:0]                   v_reg;
    logic [2:0][PW-1:0]           prod_reg;
    sdl_side_t                    side_reg;
    sdl_out_t                     result_reg;
    logic [2:0][COORD_WIDTH-1:0]  dir_next;

    always_comb
    begin
        logic [PW-1:0] rounded;
        logic [VW-1:0] v;
        for (int i = 0; i < 3; i++)
        begin
            rounded = prod_reg[i] + HALF;
            v       = rounded[PW-1:UNIT_BITS];
            if (side_reg.zero)
            begin
                dir_next[i] = '0;
            end
            else if (side_reg.neg[i])
            begin
                if (v > NEG_MAX)
                begin
                    v = NEG_MAX;
                end
                dir_next[i] = COORD_WIDTH'(-v);
            end
            else
            begin
                if (v > POS_MAX)
                begin
                    v = POS_MAX;
                end
                dir_next[i] = COORD_WIDTH'(v);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= PW'(in_side.rest) * PW'(in_u[i]);
        end
        side_reg         <= in_side;
        result_reg.dir_x <= dir_next[0];
        result_reg.dir_y <= dir_next[1];
        result_reg.dir_z <= dir_next[2];
    end

    assign done   = v_reg[1];
    assign result = result_reg;

endmodule

@@ hw/rtl/spring_direction_local_step.sv @@
// ----------------------------------------------------------------------------
// Spring direction local step
// Target direction of one spring: unit difference vector times rest length.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; busy is always low.
// Front end, 32-stage square root, 32-stage divider and back end in series.
// Reset clears every valid bit at once; data in flight is dropped.
// The receiver cannot stall, so results leave on a fixed schedule.
module spring_direction_local_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sdl_pkg::sdl_in_t  in_item,
    output logic              done,
    output sdl_pkg::sdl_out_t result
);
    import sdl_pkg::*;

    // Front end: difference, normalization and sum of squares.
    logic                  f_valid;
    logic [SUM_WIDTH-1:0]  f_sum;
    sdl_axes_t             f_a;
    sdl_side_t             f_side;

    // Square root output.
    logic                  r_valid;
    logic [ROOT_WIDTH-1:0] r_root;
    sdl_axes_t             r_a;
    sdl_side_t             r_side;

    // Divider output: unit magnitudes with 30 fraction bits.
    logic                  q_valid;
    sdl_axes_t             q_u;
    sdl_side_t             q_side;

    // Every stage advances every cycle, so a new transaction is always welcome.
    assign busy = 1'b0;

    sdl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .in_item   (in_item),
        .out_valid (f_valid),
        .out_sum   (f_sum),
        .out_a     (f_a),
        .out_side  (f_side)
    );

    sdl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_op     (f_sum),
        .in_a      (f_a),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_a     (r_a),
        .out_side  (r_side)
    );

    sdl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_root   (r_root),
        .in_a      (r_a),
        .in_side   (r_side),
        .out_valid (q_valid),
        .out_u     (q_u),
        .out_side  (q_side)
    );

    // The back end holds the output register, so the result is stable for
    // the single cycle in which done is high.
    sdl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_u     (q_u),
        .in_side  (q_side),
        .done     (done),
        .result   (result)
    );

endmodule

@@ hw/rtl/sdl_checker.sv @@
// ----------------------------------------------------------------------------
// Spring direction checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
module sdl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input sdl_pkg::sdl_in_t  in_item,
    input logic              done,
    input sdl_pkg::sdl_out_t result
);
    import sdl_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after fixed latency");

    a_zero_spring: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.first_x == in_item.second_x
         && in_item.first_y == in_item.second_y
         && in_item.first_z == in_item.second_z)
        |-> ##LATENCY (done && result == '0))
        else $error("zero-length spring gave nonzero direction");

    a_zero_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.rest_len == '0)
        |-> ##LATENCY (done && result == '0))
        else $error("zero rest length gave nonzero direction");

endmodule

bind spring_direction_local_step sdl_checker u_sdl_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .done    (done),
    .result  (result)
);

@@ test/sdl_checker.sv @@
// ----------------------------------------------------------------------------
// Spring direction checker
// Watches accepted springs, predicts each target vector and compares results.
// ----------------------------------------------------------------------------
module sdl_tb_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  sdl_pkg::sdl_in_t  in_item,
    input  logic              done,
    input  sdl_pkg::sdl_out_t result,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sdl_pkg::*;

    sdl_out_t dir_queue[$];
    int       mismatch_count;

    assign errors  = mismatch_count;
    assign pending = dir_queue.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] op);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = op;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic sdl_out_t spring_target(input sdl_in_t s);
        logic signed [COORD_WIDTH:0] d [3];
        logic [COORD_WIDTH:0]        mag [3];
        logic [63:0]                 a [3];
        logic [127:0]                prod;
        logic [63:0]                 sum;
        logic [63:0]                 root;
        logic [63:0]                 u;
        logic [63:0]                 v;
        logic [COORD_WIDTH:0]        m;
        logic [COORD_WIDTH-1:0]      outv [3];
        int                          p;
        sdl_out_t                    r;
        d[0] = {s.first_x[COORD_WIDTH-1], s.first_x} - {s.second_x[COORD_WIDTH-1], s.second_x};
        d[1] = {s.first_y[COORD_WIDTH-1], s.first_y} - {s.second_y[COORD_WIDTH-1], s.second_y};
        d[2] = {s.first_z[COORD_WIDTH-1], s.first_z} - {s.second_z[COORD_WIDTH-1], s.second_z};
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = d[i] < 0 ? -d[i] : d[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
            return '0;
        p = 0;
        while ((m >> (p + 1)) != 0)
            p++;
        for (int i = 0; i < 3; i++)
            a[i] = (p < UNIT_BITS) ? (64'(mag[i]) << (UNIT_BITS - p))
                                   : (64'(mag[i]) >> (p - UNIT_BITS));
        sum  = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        root = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            u    = ((a[i] << UNIT_BITS) + (root >> 1)) / root;
            prod = 128'(s.rest_len) * 128'(u) + (128'd1 << (UNIT_BITS - 1));
            v    = 64'(prod >> UNIT_BITS);
            if (d[i] < 0)
            begin
                if (v > 64'h8000_0000)
                    v = 64'h8000_0000;
                outv[i] = COORD_WIDTH'(-v);
            end
            else
            begin
                if (v > 64'h7FFF_FFFF)
                    v = 64'h7FFF_FFFF;
                outv[i] = COORD_WIDTH'(v);
            end
        end
        r.dir_x = outv[0];
        r.dir_y = outv[1];
        r.dir_z = outv[2];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatch_count <= 0;
        end
        else
        begin
            if (start && !busy)
                dir_queue = {dir_queue, spring_target(in_item)};
            if (done)
            begin
                if (dir_queue.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result %h", result);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    sdl_out_t want;
                    want = dir_queue.pop_front();
                    if (want.dir_x !== result.dir_x || want.dir_y !== result.dir_y
                        || want.dir_z !== result.dir_z)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected %h %h %h, got %h %h %h",
                                     want.dir_x, want.dir_y, want.dir_z,
                                     result.dir_x, result.dir_y, result.dir_z);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/tb_spring_direction_local_step.sv @@
// ----------------------------------------------------------------------------
// Spring direction local step testbench
// Directed and random springs, some after random gaps; a checker compares.
// ----------------------------------------------------------------------------
module tb_spring_direction_local_step;
    timeunit 1ns;
    timeprecision 1ps;

    import sdl_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    sdl_in_t  in_item;
    logic     done;
    sdl_out_t result;
    int       errors;
    int       pending;

    spring_direction_local_step u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .done    (done),
        .result  (result)
    );

    sdl_tb_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Picks a coordinate: full range half the time, else an extreme or a value
    // near zero, so that small differences get exercised.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    // Presents one spring at the current edge and holds it until the
    // accepting edge. The gap before it is random only when allow_idle is set;
    // start stays high so springs can follow directly.
    task automatic send_spring(input sdl_in_t s, input bit allow_idle);
        if (allow_idle)
        begin
            while ($urandom_range(0, 99) < 28)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start   <= 1'b1;
        in_item <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(input int count, input bit allow_idle);
        sdl_in_t s;
        for (int n = 0; n < count; n++)
        begin
            s.first_x = pick_coord();
            s.first_y = pick_coord();
            s.first_z = pick_coord();
            // Often place the second point close to the first.
            if ($urandom_range(0, 2) == 0)
            begin
                s.second_x = s.first_x + 32'($signed($urandom_range(0, 16)) - 8);
                s.second_y = s.first_y + 32'($signed($urandom_range(0, 16)) - 8);
                s.second_z = s.first_z + 32'($signed($urandom_range(0, 16)) - 8);
            end
            else
            begin
                s.second_x = pick_coord();
                s.second_y = pick_coord();
                s.second_z = pick_coord();
            end
            case ($urandom_range(0, 3))
                0: s.rest_len = 31'h7FFF_FFFF;
                1: s.rest_len = 31'($urandom_range(0, 1 << 18));
                default: s.rest_len = 31'($urandom);
            endcase
            send_spring(s, allow_idle);
        end
    endtask

    initial
    begin
        sdl_in_t s;
        int      wait_cycles;
        rst_n   = 1'b0;
        start   = 1'b0;
        in_item = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed springs: zero length, axis-aligned extremes, the largest
        // possible difference, a diagonal and the rest length extremes.
        s = '0;
        send_spring(s, 1'b0);
        s.rest_len = 31'h7FFF_FFFF;
        send_spring(s, 1'b0);
        s.first_x = 32'h7FFF_FFFF;
        s.second_x = 32'h8000_0000;
        send_spring(s, 1'b0);
        s = '0;
        s.first_y = 32'h8000_0000;
        s.second_y = 32'h7FFF_FFFF;
        s.rest_len = 31'h7FFF_FFFF;
        send_spring(s, 1'b0);
        s.first_z = 32'h7FFF_FFFF;
        s.second_z = 32'h8000_0000;
        send_spring(s, 1'b0);
        s = '0;
        s.first_x = 32'd1;
        s.rest_len = 31'h0001_0000;
        send_spring(s, 1'b0);
        s.second_z = 32'hFFFF_FFFF;
        send_spring(s, 1'b0);
        s = '0;
        s.first_x = 32'h0001_0000;
        s.first_y = 32'h0001_0000;
        s.first_z = 32'h0001_0000;
        s.rest_len = 31'd1;
        send_spring(s, 1'b0);
        s.second_x = 32'h8000_0000;
        s.second_y = 32'h7FFF_FFFF;
        s.second_z = 32'hFFFF_FFFF;
        s.rest_len = 31'h5555_5555;
        send_spring(s, 1'b0);
        s.first_x = 32'hFFFF_FFFF;
        s.first_y = 32'hFFFF_FFFF;
        s.first_z = 32'hFFFF_FFFF;
        s.second_x = 32'hFFFF_FFFF;
        s.second_y = 32'hFFFF_FFFF;
        s.second_z = 32'hFFFF_FFFF;
        send_spring(s, 1'b0);

        // Random part: a back-to-back stretch, then with random gaps.
        send_random(300, 1'b0);
        send_random(1150, 1'b1);
        start <= 1'b0;

        // Drain: wait for the outstanding results, with a limit.
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Generous limit well beyond the slowest correct run.
    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end
endmodule

@@ spring_direction_local_step.f @@
hw/rtl/sdl_pkg.sv
hw/rtl/sdl_front.sv
hw/rtl/sdl_sqrt.sv
hw/rtl/sdl_div.sv
hw/rtl/sdl_back.sv
hw/rtl/spring_direction_local_step.sv
hw/rtl/sdl_checker.sv
test/sdl_checker.sv
test/tb_spring_direction_local_step.sv
